/* design/eust_pkg.sv */
// Shared types, constants and a lookup function for the summer time check.
`default_nettype none

package eust_pkg;

  typedef enum logic {
    CFG_ZONE_OFFSET = 1'b0,
    CFG_LAST_SUNDAY = 1'b1
  } eust_cfg_e;

  typedef struct packed {
    logic [15:0] days;
    logic        early;
  } eust_split_t;

  typedef struct packed {
    logic [3:0] month;
    logic [4:0] mday;
    logic [2:0] wday;
    logic       early;
  } eust_civil_t;

  localparam logic signed [4:0] ZONE_OFFSET_RESET = 5'sd0;
  localparam logic [4:0]        LAST_SUNDAY_RESET = 5'd24;
  localparam logic [3:0]        MONTH_MARCH       = 4'd3;
  localparam logic [3:0]        MONTH_OCTOBER     = 4'd10;
  localparam logic [2:0]        WDAY_SUNDAY       = 3'd1;
  localparam logic [16:0]       SWITCH_SECONDS    = 17'd7200;

  // First day of month (March-based index) within the shifted year.
  function automatic logic [8:0] month_start(input logic [3:0] mp);
    logic [8:0] r;
    case (mp)
      4'd0:    r = 9'd0;
      4'd1:    r = 9'd31;
      4'd2:    r = 9'd61;
      4'd3:    r = 9'd92;
      4'd4:    r = 9'd122;
      4'd5:    r = 9'd153;
      4'd6:    r = 9'd184;
      4'd7:    r = 9'd214;
      4'd8:    r = 9'd245;
      4'd9:    r = 9'd275;
      4'd10:   r = 9'd306;
      4'd11:   r = 9'd337;
      default: r = 9'd0;
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

/* design/eust_split.sv */
// Local time offset and split into day count and early-morning flag.
`default_nettype none

module eust_split (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic                    in_valid_i,
  output logic                         in_ready_o,
  input  wire logic [31:0]             in_seconds_i,
  input  wire logic signed [4:0]       zone_offset_i,
  output logic                         out_valid_o,
  input  wire logic                    out_ready_i,
  output eust_pkg::eust_split_t        out_data_o
);

  localparam int Stages = 4;
  localparam logic signed [16:0] SecPerHour = 17'sd3600;
  localparam logic [16:0]        DayRecip   = 17'd99420;

  logic [Stages-1:0] v_q;
  logic [Stages:0]   en;

  always_comb begin
    en[Stages] = out_ready_i;
    for (int k = Stages - 1; k >= 0; k--) begin
      en[k] = ~v_q[k] | en[k+1];
    end
  end

  assign in_ready_o = en[0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (en[0]) v_q[0] <= in_valid_i;
      for (int k = 1; k < Stages; k++) begin
        if (en[k]) v_q[k] <= v_q[k-1];
      end
    end
  end

  // Stage 1: add offset, clamp at zero
  logic signed [16:0] off_sec;
  logic signed [33:0] local_sec;
  logic [32:0]        t1_d, t1_q;

  assign off_sec   = 17'(zone_offset_i) * SecPerHour;
  assign local_sec = $signed({2'b00, in_seconds_i}) + 34'(off_sec);
  assign t1_d      = local_sec[33] ? '0 : local_sec[32:0];

  // Stage 2: reciprocal estimate of days
  logic [25:0] x2_d, x2_q;
  logic [42:0] prod2;
  logic [15:0] q2_q;
  logic [6:0]  lo2_q;

  assign x2_d  = t1_q[32:7];
  assign prod2 = 43'(x2_d) * 43'(DayRecip);

  // Stage 3: remainder of estimate
  logic [25:0] sub3;
  logic [10:0] r3_q;
  logic [15:0] q3_q;
  logic [6:0]  lo3_q;

  assign sub3 = x2_q - 26'(q2_q) * 26'd675;

  // Stage 4: correct by one step
  logic        big4;
  logic [15:0] days4_d, days4_q;
  logic [10:0] r4;
  logic        early4_d, early4_q;

  assign big4     = r3_q >= 11'd675;
  assign days4_d  = q3_q + 16'(big4);
  assign r4       = big4 ? r3_q - 11'd675 : r3_q;
  assign early4_d = {r4[9:0], lo3_q} < eust_pkg::SWITCH_SECONDS;

  always_ff @(posedge clk_i) begin
    if (en[0]) t1_q <= t1_d;
    if (en[1]) begin
      x2_q  <= x2_d;
      q2_q  <= prod2[41:26];
      lo2_q <= t1_q[6:0];
    end
    if (en[2]) begin
      r3_q  <= sub3[10:0];
      q3_q  <= q2_q;
      lo3_q <= lo2_q;
    end
    if (en[3]) begin
      days4_q  <= days4_d;
      early4_q <= early4_d;
    end
  end

  assign out_valid_o = v_q[Stages-1];
  assign out_data_o  = '{days: days4_q, early: early4_q};

endmodule

`default_nettype wire

/* design/eust_civil.sv */
// Day count to month, day of month and weekday, civil-from-days pipeline.
`default_nettype none

module eust_civil (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  in_valid_i,
  output logic                       in_ready_o,
  input  wire eust_pkg::eust_split_t in_data_i,
  output logic                       out_valid_o,
  input  wire logic                  out_ready_i,
  output eust_pkg::eust_civil_t      out_data_o
);

  localparam int Stages = 9;

  logic [Stages-1:0] v_q;
  logic [Stages:0]   en;

  always_comb begin
    en[Stages] = out_ready_i;
    for (int k = Stages - 1; k >= 0; k--) begin
      en[k] = ~v_q[k] | en[k+1];
    end
  end

  assign in_ready_o = en[0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (en[0]) v_q[0] <= in_valid_i;
      for (int k = 1; k < Stages; k++) begin
        if (en[k]) v_q[k] <= v_q[k-1];
      end
    end
  end

  // Early flag travels alongside the date
  logic [Stages-1:0] e_q;

  always_ff @(posedge clk_i) begin
    if (en[0]) e_q[0] <= in_data_i.early;
    for (int k = 1; k < Stages; k++) begin
      if (en[k]) e_q[k] <= e_q[k-1];
    end
  end

  // Stage 1: day of era, weekday estimate
  logic [19:0] z1;
  logic        era5;
  logic [17:0] doe1_d, doe1_q;
  logic [15:0] wd1_d, wd1_q;
  logic [29:0] wprod1;
  logic [12:0] wq1_q;

  assign z1     = 20'(in_data_i.days) + 20'd719468;
  assign era5   = z1 >= 20'd730485;
  assign doe1_d = 18'(z1 - (era5 ? 20'd730485 : 20'd584388));
  assign wd1_d  = in_data_i.days + 16'd4;
  assign wprod1 = 30'(wd1_d) * 30'd9362;

  // Stage 2: weekday remainder, estimate of doe / 1460
  logic [15:0] wsub2;
  logic [23:0] aprod2;
  logic [17:0] doe2_q;
  logic [6:0]  aq2_q;
  logic [3:0]  wr2_q;

  assign wsub2  = wd1_q - 16'(wq1_q) * 16'd7;
  assign aprod2 = 24'(doe1_q[17:2]) * 24'd179;

  // Stage 3: weekday, remainder of doe / 1460
  logic [15:0] asub3;
  logic [3:0]  wr3;
  logic [2:0]  wday3_d;
  logic [17:0] doe3_q;
  logic [6:0]  aq3_q;
  logic [9:0]  ar3_q;
  logic [2:0]  wday_q [3:Stages];

  assign asub3   = 16'(doe2_q[17:2]) - 16'(aq2_q) * 16'd365;
  assign wr3     = (wr2_q >= 4'd7) ? wr2_q - 4'd7 : wr2_q;
  assign wday3_d = wr3[2:0] + 3'd1;

  // Stage 4: leap corrections, year numerator
  logic [6:0]  a4;
  logic [2:0]  b4;
  logic        c4;
  logic [17:0] n4_d, n4_q;
  logic [6:0]  s4_d, s4_q;

  assign a4   = aq3_q + 7'(ar3_q >= 10'd365);
  assign b4   = 3'(doe3_q >= 18'd36524) + 3'(doe3_q >= 18'd73048)
              + 3'(doe3_q >= 18'd109572) + 3'(doe3_q >= 18'd146096);
  assign c4   = doe3_q == 18'd146096;
  assign n4_d = doe3_q - 18'(a4) + 18'(b4) - 18'(c4);
  assign s4_d = a4 - 7'(b4) + 7'(c4);

  // Stage 5: estimate of year of era
  logic [27:0] yprod5;
  logic [17:0] n5_q;
  logic [8:0]  yq5_q;
  logic [6:0]  s5_q;

  assign yprod5 = 28'(n4_q) * 28'd718;

  // Stage 6: remainder of year estimate
  logic [17:0] ysub6;
  logic [8:0]  yq6_q;
  logic [9:0]  yr6_q;
  logic [6:0]  s6_q;

  assign ysub6 = n5_q - 18'(yq5_q) * 18'd365;

  // Stage 7: day of year
  logic       ybig7;
  logic [8:0] yoe7;
  logic [9:0] yr7;
  logic [1:0] cent7;
  logic [8:0] doy7_d, doy7_q;

  assign ybig7  = yr6_q >= 10'd365;
  assign yoe7   = yq6_q + 9'(ybig7);
  assign yr7    = ybig7 ? yr6_q - 10'd365 : yr6_q;
  assign cent7  = 2'(yoe7 >= 9'd100) + 2'(yoe7 >= 9'd200) + 2'(yoe7 >= 9'd300);
  assign doy7_d = 9'(s6_q) + yr7[8:0] - 9'(yoe7[8:2]) + 9'(cent7);

  // Stage 8: estimate of shifted month
  logic [10:0] v8_d, v8_q;
  logic [14:0] mprod8;
  logic [3:0]  mq8_q;
  logic [8:0]  doy8_q;

  assign v8_d   = 11'(doy7_q) * 11'd5 + 11'd2;
  assign mprod8 = 15'(v8_d) * 15'd13;

  // Stage 9: month and day of month
  logic [10:0] mr9;
  logic [3:0]  mp9;
  logic [8:0]  md9;
  logic [3:0]  month9_d, month9_q;
  logic [4:0]  mday9_q;

  assign mr9      = v8_q - 11'(mq8_q) * 11'd153;
  assign mp9      = mq8_q + 4'(mr9 >= 11'd153);
  assign md9      = doy8_q - eust_pkg::month_start(mp9) + 9'd1;
  assign month9_d = (mp9 < 4'd10) ? mp9 + 4'd3 : mp9 - 4'd9;

  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      doe1_q <= doe1_d;
      wd1_q  <= wd1_d;
      wq1_q  <= wprod1[28:16];
    end
    if (en[1]) begin
      doe2_q <= doe1_q;
      aq2_q  <= aprod2[22:16];
      wr2_q  <= wsub2[3:0];
    end
    if (en[2]) begin
      doe3_q    <= doe2_q;
      aq3_q     <= aq2_q;
      ar3_q     <= asub3[9:0];
      wday_q[3] <= wday3_d;
    end
    if (en[3]) begin
      n4_q <= n4_d;
      s4_q <= s4_d;
    end
    if (en[4]) begin
      n5_q  <= n4_q;
      yq5_q <= yprod5[26:18];
      s5_q  <= s4_q;
    end
    if (en[5]) begin
      yq6_q <= yq5_q;
      yr6_q <= ysub6[9:0];
      s6_q  <= s5_q;
    end
    if (en[6]) doy7_q <= doy7_d;
    if (en[7]) begin
      v8_q   <= v8_d;
      mq8_q  <= mprod8[14:11];
      doy8_q <= doy7_q;
    end
    if (en[8]) begin
      month9_q <= month9_d;
      mday9_q  <= md9[4:0];
    end
    for (int k = 4; k <= Stages; k++) begin
      if (en[k-1]) wday_q[k] <= wday_q[k-1];
    end
  end

  assign out_valid_o = v_q[Stages-1];
  assign out_data_o  = '{month: month9_q, mday: mday9_q, wday: wday_q[Stages],
                         early: e_q[Stages-1]};

endmodule

`default_nettype wire

/* design/eu_summer_time_check.sv */
// European summer time check: top level with register file and decision stage.
//
// Timestamps (Unix seconds, 32 bits) enter on the s_axis channel, one beat per
// item; each yields one beat on m_axis whose bit 0 is 1 while European summer
// time is in effect, using a whole-hour zone offset and a last-Sunday threshold
// held in two registers written through the cfg channel (index 0: offset,
// signed 5 bits; index 1: threshold, 5 bits). Write them only while idle.
// 4 stages split local time into days and time of day, 9 stages run the civil
// date calculation, and one output register makes the decision. Throughput is
// one beat per cycle while m_axis_tready is high.
// Each stage holds its own valid bit, so bubbles close up and a new beat is
// taken while a result waits on m_axis. When m_axis_tready is low the stages
// fill and then hold; s_axis_tready falls once the pipeline is full.
// Reset empties the pipeline and sets offset 0 and threshold 24.
`default_nettype none

module eu_summer_time_check (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [31:0] s_axis_tdata,   // [31:0] unix_seconds
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [7:0]       m_axis_tdata,   // [0] summer_time, [7:1] zero
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic        cfg_index_i,
  input  wire logic [4:0]  cfg_wdata_i
);

  logic signed [4:0] zone_q;
  logic [4:0]        thr_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      zone_q <= eust_pkg::ZONE_OFFSET_RESET;
      thr_q  <= eust_pkg::LAST_SUNDAY_RESET;
    end else if (cfg_valid_i) begin
      unique case (eust_pkg::eust_cfg_e'(cfg_index_i))
        eust_pkg::CFG_ZONE_OFFSET: zone_q <= $signed(cfg_wdata_i);
        eust_pkg::CFG_LAST_SUNDAY: thr_q  <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  logic                  split_valid, split_ready;
  eust_pkg::eust_split_t split_data;
  logic                  civil_valid, civil_ready;
  eust_pkg::eust_civil_t civil_data;

  eust_split u_split (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (s_axis_tvalid),
    .in_ready_o    (s_axis_tready),
    .in_seconds_i  (s_axis_tdata),
    .zone_offset_i (zone_q),
    .out_valid_o   (split_valid),
    .out_ready_i   (split_ready),
    .out_data_o    (split_data)
  );

  eust_civil u_civil (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (split_valid),
    .in_ready_o  (split_ready),
    .in_data_i   (split_data),
    .out_valid_o (civil_valid),
    .out_ready_i (civil_ready),
    .out_data_o  (civil_data)
  );

  // Decision stage
  logic              out_v_q;
  logic              summer_d, summer_q;
  logic signed [6:0] margin;
  logic              reached, past_switch, is_march, is_oct, mid_year;

  assign civil_ready = ~out_v_q | m_axis_tready;

  assign margin      = $signed({2'b00, civil_data.mday}) - $signed({4'b0000, civil_data.wday});
  assign reached     = margin >= $signed({2'b00, thr_q});
  assign past_switch = reached
                     & ~((civil_data.wday == eust_pkg::WDAY_SUNDAY) & civil_data.early);
  assign is_march    = civil_data.month == eust_pkg::MONTH_MARCH;
  assign is_oct      = civil_data.month == eust_pkg::MONTH_OCTOBER;
  assign mid_year    = (civil_data.month > eust_pkg::MONTH_MARCH)
                     & (civil_data.month < eust_pkg::MONTH_OCTOBER);

  always_comb begin
    if (mid_year) begin
      summer_d = 1'b1;
    end else if (is_march) begin
      summer_d = past_switch;
    end else if (is_oct) begin
      summer_d = ~past_switch;
    end else begin
      summer_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (civil_ready) begin
      out_v_q <= civil_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (civil_ready) summer_q <= summer_d;
  end

  assign m_axis_tvalid = out_v_q;
  assign m_axis_tdata  = {7'b0000000, summer_q};

endmodule

`default_nettype wire
